// ----- src/lhs_pkg.sv -----
// Shared widths, limits, reset values and codes for the lane histogram steering block.
package lhs_pkg;

   localparam int COL_W   = 9;
   localparam int ROW_W   = 9;
   localparam int COUNT_W = 10;
   localparam int TOTAL_W = 19;
   localparam int OFF_W   = 10;
   localparam int STEER_W = 3;
   localparam int INDEX_W = 3;

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
   localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

   localparam logic signed [OFF_W-1:0] OFF_NEAR = 10'sd10;
   localparam logic signed [OFF_W-1:0] OFF_FAR  = 10'sd20;

   localparam logic [ROW_W-1:0]   RST_TOP_ROW     = 9'd140;
   localparam logic [ROW_W-1:0]   RST_BOTTOM_ROW  = 9'd239;
   localparam logic [COL_W-1:0]   RST_LEFT_END    = 9'd149;
   localparam logic [COL_W-1:0]   RST_RIGHT_START = 9'd250;
   localparam logic [COL_W-1:0]   RST_RIGHT_END   = 9'd399;
   localparam logic [COL_W-1:0]   RST_CENTRE      = 9'd188;
   localparam logic [TOTAL_W-1:0] RST_END_LIMIT   = 19'd4000;

   typedef enum logic [INDEX_W-1:0] {
      CSR_TOP_ROW     = 3'd0,
      CSR_BOTTOM_ROW  = 3'd1,
      CSR_LEFT_END    = 3'd2,
      CSR_RIGHT_START = 3'd3,
      CSR_RIGHT_END   = 3'd4,
      CSR_CENTRE      = 3'd5,
      CSR_END_LIMIT   = 3'd6
   } csr_index_type;

   typedef enum logic [STEER_W-1:0] {
      STEER_FWD     = 3'd0,
      STEER_RIGHT_1 = 3'd1,
      STEER_RIGHT_2 = 3'd2,
      STEER_RIGHT_3 = 3'd3,
      STEER_LEFT_1  = 3'd4,
      STEER_LEFT_2  = 3'd5,
      STEER_LEFT_3  = 3'd6
   } steer_type;

endpackage

// ----- src/lhs_ifs.sv -----
// Pixel, result and register-write channel interfaces.
interface lhs_req_if;
   import lhs_pkg::*;
   logic               valid;
   logic               ready;
   logic               pixel_on;
   logic [COL_W-1:0]   column;
   logic [ROW_W-1:0]   row;
   logic               frame_last;
   modport source (output valid, pixel_on, column, row, frame_last, input ready);
   modport sink   (input valid, pixel_on, column, row, frame_last, output ready);
endinterface

interface lhs_rsp_if;
   import lhs_pkg::*;
   logic                      valid;
   logic                      ready;
   logic [COL_W-1:0]          left_pos;
   logic [COL_W-1:0]          right_pos;
   logic [COL_W-1:0]          lane_mid;
   logic signed [OFF_W-1:0]   offset;
   logic [STEER_W-1:0]        steer_code;
   logic                      lane_end;
   logic [TOTAL_W-1:0]        white_total;
   modport source (output valid, left_pos, right_pos, lane_mid, offset, steer_code,
                   lane_end, white_total, input ready);
   modport sink   (input valid, left_pos, right_pos, lane_mid, offset, steer_code,
                   lane_end, white_total, output ready);
endinterface

interface lhs_csr_if;
   import lhs_pkg::*;
   logic                 valid;
   logic                 ready;
   csr_index_type        reg_index;
   logic [TOTAL_W-1:0]   wdata;
   modport source (output valid, reg_index, wdata, input ready);
   modport sink   (input valid, reg_index, wdata, output ready);
endinterface

// ----- src/lane_histogram_steering.sv -----
// A result passes the input, summary and result registers once the frame's last word is accepted.
// Throughput: one pixel word per cycle unless a frame end waits on a held result; column counts
// are read at accept, written from the input register, with a one-entry bypass for back-to-back columns.
// Reset: registers to defaults, frame totals and lane searches cleared, pipeline empty.
// Column counts are not cleared; each is loaded on the window's top row.
module lane_histogram_steering #(
   parameter int MAX_WIDTH = 512
) (
   input  logic      clock,
   input  logic      reset,
   lhs_req_if.sink   req_ch,
   lhs_rsp_if.source rsp_ch,
   lhs_csr_if.sink   csr_ch
);
   import lhs_pkg::*;

   localparam int AW = $clog2(MAX_WIDTH);
   localparam int CW = (AW > COL_W) ? AW : COL_W;

   // configuration
   logic [ROW_W-1:0]   top_row_ff, bottom_row_ff;
   logic [COL_W-1:0]   left_end_ff, right_start_ff, right_end_ff, centre_ff;
   logic [TOTAL_W-1:0] end_limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         top_row_ff     <= RST_TOP_ROW;
         bottom_row_ff  <= RST_BOTTOM_ROW;
         left_end_ff    <= RST_LEFT_END;
         right_start_ff <= RST_RIGHT_START;
         right_end_ff   <= RST_RIGHT_END;
         centre_ff      <= RST_CENTRE;
         end_limit_ff   <= RST_END_LIMIT;
      end else if (csr_ch.valid && csr_ch.ready) begin
         unique case (csr_ch.reg_index)
            CSR_TOP_ROW:     top_row_ff     <= csr_ch.wdata[ROW_W-1:0];
            CSR_BOTTOM_ROW:  bottom_row_ff  <= csr_ch.wdata[ROW_W-1:0];
            CSR_LEFT_END:    left_end_ff    <= csr_ch.wdata[COL_W-1:0];
            CSR_RIGHT_START: right_start_ff <= csr_ch.wdata[COL_W-1:0];
            CSR_RIGHT_END:   right_end_ff   <= csr_ch.wdata[COL_W-1:0];
            CSR_CENTRE:      centre_ff      <= csr_ch.wdata[COL_W-1:0];
            CSR_END_LIMIT:   end_limit_ff   <= csr_ch.wdata;
            default: ;
         endcase
      end
   end

   assign csr_ch.ready = 1'b1;

   // pipeline control
   logic s1_valid_ff, s1_valid_in;
   logic p_valid_ff, p_valid_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic req_fire, commit, rsp_adv, p_adv, p_free;
   logic s1_pix_ff, s1_last_ff;
   logic [COL_W-1:0] s1_col_ff;
   logic [ROW_W-1:0] s1_row_ff;

   assign rsp_adv  = !rsp_valid_ff || rsp_ch.ready;
   assign p_adv    = p_valid_ff && rsp_adv;
   assign p_free   = !p_valid_ff || rsp_adv;
   assign commit   = s1_valid_ff && (!s1_last_ff || p_free);
   assign req_fire = req_ch.valid && req_ch.ready;
   assign req_ch.ready = !s1_valid_ff || commit;

   always_comb begin
      s1_valid_in  = req_fire ? 1'b1 : (commit ? 1'b0 : s1_valid_ff);
      p_valid_in   = (commit && s1_last_ff) ? 1'b1 : (p_adv ? 1'b0 : p_valid_ff);
      rsp_valid_in = p_adv ? 1'b1 : (rsp_ch.ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         p_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         p_valid_ff   <= p_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_pix_ff  <= req_ch.pixel_on;
         s1_col_ff  <= req_ch.column;
         s1_row_ff  <= req_ch.row;
         s1_last_ff <= req_ch.frame_last;
      end
   end

   // column count memory
   logic [COUNT_W-1:0] count_mem [MAX_WIDTH];
   logic [COUNT_W-1:0] rd_ff, cur_count, cnt_in;
   logic [CW-1:0]      req_col_wide, s1_col_wide;
   logic [AW-1:0]      req_addr, s1_addr;
   logic               wr_valid_ff;
   logic [AW-1:0]      wr_addr_ff;
   logic [COUNT_W-1:0] wr_val_ff;
   logic               col_ok, in_win, at_top, at_bot, mem_we;

   assign req_col_wide = CW'(req_ch.column);
   assign s1_col_wide  = CW'(s1_col_ff);
   assign req_addr     = req_col_wide[AW-1:0];
   assign s1_addr      = s1_col_wide[AW-1:0];

   assign col_ok = int'(s1_col_ff) < MAX_WIDTH;
   assign in_win = col_ok && (s1_row_ff >= top_row_ff) && (s1_row_ff <= bottom_row_ff);
   assign at_top = s1_row_ff == top_row_ff;
   assign at_bot = s1_row_ff == bottom_row_ff;
   assign mem_we = commit && in_win;

   always_comb begin
      cur_count = (wr_valid_ff && (wr_addr_ff == s1_addr)) ? wr_val_ff : rd_ff;
      if (at_top)
         cnt_in = COUNT_W'(s1_pix_ff);
      else if (s1_pix_ff && (cur_count != COUNT_MAX))
         cnt_in = cur_count + COUNT_W'(1);
      else
         cnt_in = cur_count;
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rd_ff <= count_mem[req_addr];
      end
      if (mem_we) begin
         count_mem[s1_addr] <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_valid_ff <= 1'b0;
      end else if (mem_we) begin
         wr_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         wr_addr_ff <= s1_addr;
         wr_val_ff  <= cnt_in;
      end
   end

   // frame accumulators
   logic               lseen_ff, lseen_in, rseen_ff, rseen_in;
   logic [COUNT_W-1:0] lbest_ff, lbest_in, rbest_ff, rbest_in;
   logic [COL_W-1:0]   lcol_ff, lcol_in, rcol_ff, rcol_in;
   logic [TOTAL_W-1:0] total_ff, total_in;
   logic               lcand, rcand;
   logic [COL_W-1:0]   lcol_upd, rcol_upd;
   logic [TOTAL_W-1:0] total_upd;

   assign lcand = in_win && at_bot && (s1_col_ff <= left_end_ff)
                  && (!lseen_ff || (cnt_in > lbest_ff));
   assign rcand = in_win && at_bot && (s1_col_ff >= right_start_ff)
                  && (s1_col_ff <= right_end_ff) && (!rseen_ff || (cnt_in > rbest_ff));
   assign lcol_upd  = lcand ? s1_col_ff : lcol_ff;
   assign rcol_upd  = rcand ? s1_col_ff : rcol_ff;
   assign total_upd = (s1_pix_ff && (total_ff != TOTAL_MAX)) ? total_ff + TOTAL_W'(1)
                                                             : total_ff;

   always_comb begin
      lseen_in = lseen_ff;
      rseen_in = rseen_ff;
      lbest_in = lbest_ff;
      rbest_in = rbest_ff;
      lcol_in  = lcol_ff;
      rcol_in  = rcol_ff;
      total_in = total_ff;
      if (commit) begin
         if (s1_last_ff) begin
            lseen_in = 1'b0;
            rseen_in = 1'b0;
            lbest_in = '0;
            rbest_in = '0;
            lcol_in  = '0;
            rcol_in  = '0;
            total_in = '0;
         end else begin
            lseen_in = lseen_ff || lcand;
            rseen_in = rseen_ff || rcand;
            lbest_in = lcand ? cnt_in : lbest_ff;
            rbest_in = rcand ? cnt_in : rbest_ff;
            lcol_in  = lcol_upd;
            rcol_in  = rcol_upd;
            total_in = total_upd;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lseen_ff <= 1'b0;
         rseen_ff <= 1'b0;
         lbest_ff <= '0;
         rbest_ff <= '0;
         lcol_ff  <= '0;
         rcol_ff  <= '0;
         total_ff <= '0;
      end else begin
         lseen_ff <= lseen_in;
         rseen_ff <= rseen_in;
         lbest_ff <= lbest_in;
         rbest_ff <= rbest_in;
         lcol_ff  <= lcol_in;
         rcol_ff  <= rcol_in;
         total_ff <= total_in;
      end
   end

   // frame summary stage
   logic [COL_W-1:0]   p_left_ff, p_right_ff;
   logic [TOTAL_W-1:0] p_total_ff;

   always_ff @(posedge clock) begin
      if (commit && s1_last_ff) begin
         p_left_ff  <= lcol_upd;
         p_right_ff <= rcol_upd;
         p_total_ff <= total_upd;
      end
   end

   // steering
   logic signed [OFF_W-1:0] diff, half, mid_s, off;
   logic [COL_W-1:0]        mid;
   steer_type               steer;

   always_comb begin
      diff  = $signed({1'b0, p_right_ff}) - $signed({1'b0, p_left_ff});
      half  = (diff + $signed({{(OFF_W-1){1'b0}}, diff[OFF_W-1]})) >>> 1;
      mid_s = $signed({1'b0, p_left_ff}) + half;
      mid   = mid_s[COL_W-1:0];
      off   = $signed({1'b0, mid}) - $signed({1'b0, centre_ff});
      if (off == '0)
         steer = STEER_FWD;
      else if (!off[OFF_W-1])
         steer = (off < OFF_NEAR) ? STEER_RIGHT_1 :
                 ((off < OFF_FAR) ? STEER_RIGHT_2 : STEER_RIGHT_3);
      else
         steer = (off > -OFF_NEAR) ? STEER_LEFT_1 :
                 ((off > -OFF_FAR) ? STEER_LEFT_2 : STEER_LEFT_3);
   end

   // result word
   logic [COL_W-1:0]        rsp_left_ff, rsp_right_ff, rsp_mid_ff;
   logic signed [OFF_W-1:0] rsp_off_ff;
   steer_type               rsp_steer_ff;
   logic                    rsp_end_ff;
   logic [TOTAL_W-1:0]      rsp_total_ff;

   always_ff @(posedge clock) begin
      if (p_adv) begin
         rsp_left_ff  <= p_left_ff;
         rsp_right_ff <= p_right_ff;
         rsp_mid_ff   <= mid;
         rsp_off_ff   <= off;
         rsp_steer_ff <= steer;
         rsp_end_ff   <= p_total_ff > end_limit_ff;
         rsp_total_ff <= p_total_ff;
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.left_pos    = rsp_left_ff;
   assign rsp_ch.right_pos   = rsp_right_ff;
   assign rsp_ch.lane_mid    = rsp_mid_ff;
   assign rsp_ch.offset      = rsp_off_ff;
   assign rsp_ch.steer_code  = rsp_steer_ff;
   assign rsp_ch.lane_end    = rsp_end_ff;
   assign rsp_ch.white_total = rsp_total_ff;

endmodule

// ----- src/lhs_check.sv -----
// Port-level checks for the lane histogram steering block, bound to its top level.
module lhs_check (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_ready,
   input logic                              req_last,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic [lhs_pkg::COL_W-1:0]         rsp_left,
   input logic [lhs_pkg::COL_W-1:0]         rsp_right,
   input logic [lhs_pkg::COL_W-1:0]         rsp_mid,
   input logic signed [lhs_pkg::OFF_W-1:0]  rsp_offset,
   input logic [lhs_pkg::STEER_W-1:0]       rsp_steer
);
   import lhs_pkg::*;

   logic [2:0] pend_ff, pend_in;

   always_comb begin
      pend_in = pend_ff;
      if (req_valid && req_ready && req_last)
         pend_in = pend_in + 3'd1;
      if (rsp_valid && rsp_ready)
         pend_in = pend_in - 3'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_offset) && $stable(rsp_mid))
      else $error("result word dropped or changed while stalled");

   a_rsp_needs_frame: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pend_ff != 3'd0)
      else $error("result word without a frame end");

   a_pend_depth: assert property (@(posedge clock) disable iff (reset)
      pend_ff <= 3'd3)
      else $error("more frame ends in flight than the pipeline holds");

   a_steer_sign: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_offset == '0) == (rsp_steer == STEER_FWD))
         && ((rsp_offset > 0) == (rsp_steer == STEER_RIGHT_1 || rsp_steer == STEER_RIGHT_2
                                  || rsp_steer == STEER_RIGHT_3)))
      else $error("steering code disagrees with offset sign");

   a_mid_between: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_left <= rsp_right)
                       ? (rsp_mid >= rsp_left && rsp_mid <= rsp_right)
                       : (rsp_mid <= rsp_left && rsp_mid >= rsp_right)))
      else $error("midpoint outside lane positions");

endmodule

bind lane_histogram_steering lhs_check u_lhs_check (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_ch.valid),
   .req_ready  (req_ch.ready),
   .req_last   (req_ch.frame_last),
   .rsp_valid  (rsp_ch.valid),
   .rsp_ready  (rsp_ch.ready),
   .rsp_left   (rsp_ch.left_pos),
   .rsp_right  (rsp_ch.right_pos),
   .rsp_mid    (rsp_ch.lane_mid),
   .rsp_offset (rsp_ch.offset),
   .rsp_steer  (rsp_ch.steer_code)
);
